// ===== design/sha224_pkg.sv =====
// shared types, constants and the rotate helper for the sha-224 stream hasher
package sha224_pkg;

    localparam logic [31:0] IV [0:7] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam logic [7:0] PAD_BYTE = 8'b10000000;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // classified beat handed from the front part to the back part
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;   // 0..4 valid leading bytes
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/sha224_stream_hasher_top.sv =====
// top level of the sha-224 stream hasher
// flow: beats are registered in the front queue; after the last beat come padding steps and one
//   length step, then one or two block compressions, then seven digest beats
// input pacing: set by the one-round-per-cycle compression loop; 16 beats fill a block, then
//   the 64 rounds run while new beats wait in the front queue
// reset: rst_n asynchronous active low; chain returns to the sha-224 iv, counts to zero
module sha224_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero pad
    input  logic        s_axis_tlast,   // last
    // digest beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero pad
    output logic        m_axis_tlast    // last_word
);

    logic              q_valid, q_ready;
    sha224_pkg::item_t q_item;

    // front: normalise byte count and buffer up to two beats ahead of the rounds
    sha224_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata[31:0]),
        .in_count (s_axis_tdata[34:32]),
        .in_last  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    logic [31:0] digest;
    logic [2:0]  index;

    // back: byte packing, padding and the round loop
    sha224_round_engine u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_digest (digest),
        .out_index  (index),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, index, digest};

endmodule

// ===== design/sha224_front.sv =====
// input stage: normalises the byte count and queues beats for the core
module sha224_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_data,
    input  logic [2:0]          in_count,
    input  logic                in_last,
    output logic                q_valid,
    input  logic                q_ready,
    output sha224_pkg::item_t   q_item
);

    sha224_pkg::item_t slot_reg [0:sha224_pkg::QUEUE_DEPTH-1];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] level_reg;
    sha224_pkg::item_t item;
    logic push, pop;

    always_comb
    begin
        item.data  = in_data;
        item.last  = in_last;
        item.count = (!in_last || in_count > 3'd4) ? 3'd4 : in_count;
    end

    assign in_ready = (level_reg != 2'(sha224_pkg::QUEUE_DEPTH));
    assign q_valid  = (level_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_reg + 2'(push) - 2'(pop);
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= 2'(sha224_pkg::QUEUE_DEPTH))
        else $error("queue level out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    a_count_norm: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (item.count <= 3'd4))
        else $error("count not normalised");

endmodule

// ===== design/sha224_core.sv =====
// back part: block gathering, padding, 64-round compression, digest output
module sha224_round_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  sha224_pkg::item_t  q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_digest,
    output logic [2:0]         out_index,
    output logic               out_last
);

    sha224_pkg::state_t state_reg, state_next;
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_reg [0:15];       // rolling schedule window, word 0 is current
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    logic        final_reg;          // block in flight is the length block
    logic        after_len_reg;      // block in flight is followed by length padding
    logic        pad_sent_reg;       // 0x80 marker already written

    // byte-wise writes into the block window
    logic [31:0] wnew [0:15];
    logic [5:0]  fill_new;
    logic        blk_full;
    logic        take, pad_step;
    logic [2:0]  nbytes;
    logic [31:0] src;

    always_comb
    begin
        logic [5:0] p;
        for (int i = 0; i < 16; i++)
            wnew[i] = w_reg[i];
        p = fill_reg;
        blk_full = 1'b0;
        for (int b = 0; b < 4; b++)
        begin
            if (3'(b) < nbytes)
            begin
                wnew[p[5:2]][8*(3-p[1:0]) +: 8] = src[8*(3-b) +: 8];
                if (p == 6'd63)
                    blk_full = 1'b1;
                p = p + 6'd1;
            end
        end
        fill_new = p;
    end

    // data bytes, or one pad byte then zeros
    always_comb
    begin
        if (state_reg == sha224_pkg::ST_IDLE)
        begin
            nbytes = q_item.count;
            src    = q_item.data;
        end
        else
        begin
            nbytes = 3'd1;
            src    = {(pad_sent_reg ? 8'h00 : sha224_pkg::PAD_BYTE), 24'h0};
        end
    end

    assign q_ready = (state_reg == sha224_pkg::ST_IDLE);
    assign take    = q_valid && q_ready;
    assign pad_step = (state_reg == sha224_pkg::ST_PAD);

    // round datapath
    logic [31:0] t1, t2, s0, s1, wnext;
    always_comb
    begin
        s0 = sha224_pkg::rotr(w_reg[1], 7) ^ sha224_pkg::rotr(w_reg[1], 18)
           ^ (w_reg[1] >> 3);
        s1 = sha224_pkg::rotr(w_reg[14], 17) ^ sha224_pkg::rotr(w_reg[14], 19)
           ^ (w_reg[14] >> 10);
        wnext = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (sha224_pkg::rotr(v_reg[4], 6) ^ sha224_pkg::rotr(v_reg[4], 11)
           ^ sha224_pkg::rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha224_pkg::K[round_reg] + w_reg[0];
        t2 = (sha224_pkg::rotr(v_reg[0], 2) ^ sha224_pkg::rotr(v_reg[0], 13)
           ^ sha224_pkg::rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha224_pkg::ST_IDLE:
                if (take)
                begin
                    if (blk_full)
                        state_next = sha224_pkg::ST_COMP;
                    else if (q_item.last)
                        state_next = sha224_pkg::ST_PAD;
                end
            sha224_pkg::ST_PAD:
                if (blk_full)
                    state_next = sha224_pkg::ST_COMP;
                else if (fill_new == 6'd56)
                    state_next = sha224_pkg::ST_LEN;
            sha224_pkg::ST_LEN:
                state_next = sha224_pkg::ST_COMP;
            sha224_pkg::ST_COMP:
                if (round_reg == 6'd63)
                begin
                    if (final_reg)
                        state_next = sha224_pkg::ST_EMIT;
                    else if (after_len_reg)
                        state_next = sha224_pkg::ST_PAD;
                    else
                        state_next = sha224_pkg::ST_IDLE;
                end
            sha224_pkg::ST_EMIT:
                if (out_ready && emit_reg == 3'd6)
                    state_next = sha224_pkg::ST_IDLE;
            default:
                state_next = sha224_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        out_valid  = (state_reg == sha224_pkg::ST_EMIT);
        out_digest = h_reg[emit_reg];
        out_index  = emit_reg;
        out_last   = (emit_reg == 3'd6);
    end

    always_ff @(posedge clk)
    begin
        if (take || pad_step)
            for (int i = 0; i < 16; i++)
                w_reg[i] <= wnew[i];
        else if (state_reg == sha224_pkg::ST_LEN)
        begin
            w_reg[14] <= bits_reg[63:32];
            w_reg[15] <= bits_reg[31:0];
        end
        else if (state_reg == sha224_pkg::ST_COMP)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnext;
        end
        if (state_reg == sha224_pkg::ST_COMP)
        begin
            for (int i = 1; i < 8; i++)
                if (i != 4)
                    v_reg[i] <= v_reg[i-1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
        else
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha224_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha224_pkg::IV[i];
            fill_reg      <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            emit_reg      <= '0;
            final_reg     <= 1'b0;
            after_len_reg <= 1'b0;
            pad_sent_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                fill_reg <= fill_new;
                bits_reg <= bits_reg + 64'({q_item.count, 3'b000});
                after_len_reg <= q_item.last;
                pad_sent_reg <= 1'b0;
                final_reg <= 1'b0;
            end
            else if (pad_step)
            begin
                fill_reg <= fill_new;
                after_len_reg <= 1'b1;
                pad_sent_reg <= 1'b1;
            end
            if (state_reg == sha224_pkg::ST_LEN)
                final_reg <= 1'b1;
            if (state_reg == sha224_pkg::ST_COMP)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + ((i == 0) ? t1 + t2 :
                                    (i == 4) ? v_reg[3] + t1 : v_reg[i-1]);
            end
            if (state_reg == sha224_pkg::ST_EMIT && out_ready)
            begin
                if (emit_reg == 3'd6)
                begin
                    emit_reg <= '0;
                    fill_reg <= '0;
                    bits_reg <= '0;
                    final_reg <= 1'b0;
                    after_len_reg <= 1'b0;
                    pad_sent_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= sha224_pkg::IV[i];
                end
                else
                    emit_reg <= emit_reg + 3'd1;
            end
        end
    end

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha224_pkg::ST_COMP) |-> (round_reg == 6'd0))
        else $error("round counter moved outside compression");
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (state_reg == sha224_pkg::ST_IDLE))
        else $error("digest not followed by idle");
    a_len_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha224_pkg::ST_LEN) |-> (fill_reg == 6'd56))
        else $error("length written at wrong fill");

endmodule
